@@ rtl/core/svf_pkg.sv @@
package svf_pkg;

    localparam int unsigned DATA_W        = 32;
    localparam int unsigned SAMPLE_BITS_D = 32;
    localparam int unsigned NUM_REGS      = 7;
    localparam int unsigned CFG_ADDR_W    = 3;

    // register map
    localparam logic [CFG_ADDR_W-1:0] REG_CUTOFF = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DAMP   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LOW_G  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_HIGH_G = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_BAND_G = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_NOTCH_G = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE, ST_S0, ST_S1, ST_S2, ST_S3, ST_S4, ST_S5, ST_S6, ST_S7, ST_S8
    } t_state;

    typedef enum logic [3:0] {
        DP_HOLD, DP_LOAD, DP_S0, DP_S1, DP_S2, DP_S3, DP_S4, DP_S5, DP_S6, DP_S7, DP_S8
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

endpackage

@@ rtl/core/svf_ctrl.sv @@
module svf_ctrl
    import svf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.op    = DP_HOLD;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = ST_S0;
                end
            end
            ST_S0: begin o_cmd.op = DP_S0; n_state = ST_S1; end
            ST_S1: begin o_cmd.op = DP_S1; n_state = ST_S2; end
            ST_S2: begin o_cmd.op = DP_S2; n_state = ST_S3; end
            ST_S3: begin o_cmd.op = DP_S3; n_state = ST_S4; end
            ST_S4: begin o_cmd.op = DP_S4; n_state = ST_S5; end
            ST_S5: begin o_cmd.op = DP_S5; n_state = ST_S6; end
            ST_S6: begin o_cmd.op = DP_S6; n_state = ST_S7; end
            ST_S7: begin o_cmd.op = DP_S7; n_state = ST_S8; end
            ST_S8: begin
                // final add lands in the output register once it is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = DP_S8;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/core/svf_dp.sv @@
module svf_dp
    import svf_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_D
) (
    input  logic                  i_clk,
    input  t_dp_cmd               i_cmd,
    input  logic [DATA_W-1:0]     i_sample,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [DATA_W-1:0]     i_cfg_wdata,
    input  logic                  i_rst_n,
    output logic [DATA_W-1:0]     o_sample
);

    localparam int unsigned W = SAMPLE_BITS;

    typedef logic signed [W-1:0] t_q;

    function automatic t_q f_sat(input logic signed [W+1:0] v);
        logic signed [W+1:0] hi;
        logic signed [W+1:0] lo;
        hi = (W+2)'({1'b0, {(W-1){1'b1}}});
        lo = -hi - (W+2)'(1);
        if (v > hi)      f_sat = t_q'(hi);
        else if (v < lo) f_sat = t_q'(lo);
        else             f_sat = t_q'(v);
    endfunction

    function automatic t_q f_add(input t_q a, input t_q b);
        f_add = f_sat((W+2)'(a) + (W+2)'(b));
    endfunction

    function automatic t_q f_sub(input t_q a, input t_q b);
        f_sub = f_sat((W+2)'(a) - (W+2)'(b));
    endfunction

    t_q                     r_cfg [NUM_REGS];
    t_q                     r_x, r_low, r_band, r_high, r_notch, r_xs, r_acc;
    t_q                     r_sample_out;
    logic signed [2*W-1:0]  r_prod;
    t_q                     mul_a, mul_b, q_prod;
    logic signed [W:0]      prod_sh;

    // floor shift by W-1 is the upper W+1 bits of the product
    assign prod_sh = r_prod[2*W-1:W-1];
    assign q_prod  = f_sat((W+2)'(prod_sh));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) r_cfg[i] <= '0;
        end else if (i_cfg_we && (i_cfg_addr < CFG_ADDR_W'(NUM_REGS))) begin
            r_cfg[i_cfg_addr] <= t_q'(i_cfg_wdata[W-1:0]);
        end
    end

    always_comb begin
        mul_a = r_cfg[REG_CUTOFF];
        mul_b = r_band;
        unique case (i_cmd.op)
            DP_S1:   begin mul_a = r_x;      mul_b = r_cfg[REG_SCALE];   end
            DP_S2:   begin mul_a = r_cfg[REG_DAMP]; mul_b = r_band;      end
            DP_S3:   begin mul_a = r_low;    mul_b = r_cfg[REG_LOW_G];   end
            DP_S4:   begin mul_a = r_cfg[REG_CUTOFF]; mul_b = r_high;    end
            DP_S5:   begin mul_a = r_high;   mul_b = r_cfg[REG_HIGH_G];  end
            DP_S6:   begin mul_a = r_band;   mul_b = r_cfg[REG_BAND_G];  end
            DP_S7:   begin mul_a = r_notch;  mul_b = r_cfg[REG_NOTCH_G]; end
            default: begin mul_a = r_cfg[REG_CUTOFF]; mul_b = r_band;    end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= '0;
            r_band <= '0;
        end else begin
            unique case (i_cmd.op)
                DP_LOAD: r_x <= t_q'(i_sample[W-1:0]);
                DP_S0:   r_prod <= mul_a * mul_b;
                DP_S1: begin
                    r_low  <= f_add(r_low, q_prod);
                    r_prod <= mul_a * mul_b;
                end
                DP_S2: begin
                    r_xs   <= q_prod;
                    r_prod <= mul_a * mul_b;
                end
                DP_S3: begin
                    r_high <= f_sub(f_sub(r_xs, q_prod), r_low);
                    r_prod <= mul_a * mul_b;
                end
                DP_S4: begin
                    r_acc   <= q_prod;
                    r_notch <= f_add(r_low, r_high);
                    r_prod  <= mul_a * mul_b;
                end
                DP_S5: begin
                    r_band <= f_add(r_band, q_prod);
                    r_prod <= mul_a * mul_b;
                end
                DP_S6, DP_S7: begin
                    r_acc  <= f_add(r_acc, q_prod);
                    r_prod <= mul_a * mul_b;
                end
                DP_S8:   r_sample_out <= f_add(r_acc, q_prod);
                default: ;
            endcase
        end
    end

    assign o_sample = DATA_W'(r_sample_out);

endmodule

@@ rtl/core/state_variable_filter_mix.sv @@
// Each accepted input is loaded, then steps S0 to S8 run; S8 waits for a free output register.
// One sample is in flight at a time; one shared multiplier runs eight products in sequence,
// plus a load step and a final mix add.
// Next input is taken while a finished sample still waits on the output side.
// Reset (synchronous, active low) clears both integrators, config registers and output valid.
module state_variable_filter_mix
    import svf_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_D
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [DATA_W-1:0]     s_axis_tdata,   // [31:0] sample_in
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [DATA_W-1:0]     m_axis_tdata,   // [31:0] sample_out
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [DATA_W-1:0]     i_cfg_wdata
);

    t_dp_cmd cmd;

    svf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    svf_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .i_sample    (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rst_n     (i_rst_n),
        .o_sample    (m_axis_tdata)
    );

endmodule

@@ rtl/core/svf_checker.sv @@
module svf_checker
    import svf_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [DATA_W-1:0] m_axis_tdata
);

    logic s_beat;
    assign s_beat = s_axis_tvalid && s_axis_tready;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output beat changed");

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_beat |-> ##9 !s_axis_tready)
        else $error("input taken before step finished");

    a_no_out_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_beat && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("output appeared too early");

endmodule

bind state_variable_filter_mix svf_checker u_svf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
